// ===== rtl/core/hsc_pkg.sv =====
// Package for the humidity sample conditioner: types, codes and constants.
// Used by every module under rtl/core; has no dependencies of its own.
package hsc_pkg;

  localparam int TimeW    = 32;
  localparam int ValW     = 16;
  localparam int HumW     = 14;
  localparam int RateW    = 10;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 16;

  // Rate numerator is |delta| * 1000 with |delta| <= 10000, so 24 bits hold it.
  localparam int DivNumW  = 24;
  localparam int DivDenW  = TimeW;

  localparam logic [CfgDataW-1:0] MinIntervalReset = 16'd2000;
  localparam logic [ValW-1:0]     HumMax           = 16'd10000;
  localparam logic [TimeW-1:0]    MinDtMs          = 32'd100;
  localparam logic [DivNumW-1:0]  RateLimit        = 24'd500;
  localparam int                  ChangeThreshold  = 5;

  localparam logic [CfgIdxW-1:0] CFG_MIN_INTERVAL   = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_SENSOR_PRESENT = 1'd1;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_DISABLED  = 2'd1,
    ERR_READ_FAIL = 2'd2,
    ERR_HUM_RANGE = 2'd3
  } err_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DIV  = 1'b1
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/core/hsc_div.sv =====
// Bit-serial restoring divider: one quotient bit per clock cycle.
// Depends on hsc_pkg for the status struct.
module hsc_div #(
  parameter int NumW = hsc_pkg::DivNumW,
  parameter int DenW = hsc_pkg::DivDenW
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [NumW-1:0]         dividend,
  input  logic [DenW-1:0]         divisor,
  output hsc_pkg::div_stat_t      stat,
  output logic [NumW-1:0]         quotient
);
  import hsc_pkg::*;

  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0] work;
  logic [DenW-1:0] rem;
  logic [DenW-1:0] den;
  logic [CntW-1:0] cnt;
  logic            busy;
  logic            done;

  logic [DenW:0]   shifted;
  logic [DenW:0]   trial;
  logic            fits;

  // The dividend shifts out at the top while quotient bits shift in at the bottom.
  assign shifted = {rem, work[NumW-1]};
  assign trial   = shifted - {1'b0, den};
  assign fits    = (shifted >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(NumW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
      den  <= divisor;
    end else if (busy) begin
      work <= {work[NumW-2:0], fits};
      rem  <= fits ? trial[DenW-1:0] : shifted[DenW-1:0];
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = work;

endmodule

// ===== rtl/core/humidity_sample_conditioner_core.sv =====
// Top level of the humidity sample conditioner: poll gating, health tracking,
// sample cache and humidity rate. Depends on hsc_pkg and hsc_div.
//
// Each transaction on the input channel yields exactly one result transaction.
// Items that are refused, too early, failed, out of range, first-valid or
// within 100 ms of the previous valid sample finish without the divider. An item
// that updates the humidity rate waits for the bit-serial divider, which
// produces the 24-bit quotient of |delta| * 1000 by the elapsed time one bit
// per cycle, followed by clamping. The block holds one item at a time and
// takes a new one only when the result register is empty or being drained.
module humidity_sample_conditioner_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [hsc_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [hsc_pkg::CfgDataW-1:0]      cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [hsc_pkg::TimeW-1:0]         now_ms,
  input  logic                              read_ok,
  input  logic signed [hsc_pkg::ValW-1:0]   temperature,
  input  logic signed [hsc_pkg::ValW-1:0]   humidity,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              polled,
  output logic                              changed,
  output logic                              healthy,
  output logic [1:0]                        error_code,
  output logic signed [hsc_pkg::RateW-1:0]  hum_rate,
  output logic signed [hsc_pkg::ValW-1:0]   cached_temperature,
  output logic [hsc_pkg::HumW-1:0]          cached_humidity
);
  import hsc_pkg::*;

  // Configuration registers.
  logic [CfgDataW-1:0] min_interval_ms;
  logic                sensor_present;

  // Conditioner state.
  logic [TimeW-1:0]        last_poll_time;
  logic [TimeW-1:0]        last_valid_time;
  logic                    have_valid_time;
  logic [HumW-1:0]         last_valid_hum;
  logic signed [ValW-1:0]  temp_cache;
  logic [HumW-1:0]         hum_cache;
  logic signed [RateW-1:0] rate_reg;
  logic                    ok_flag;
  logic                    polled_q;
  logic                    changed_q;
  err_t                    err_q;
  logic                    rate_neg;
  logic                    out_full;

  state_t state;
  state_t state_next;

  logic            accept;
  logic            out_free;
  logic            div_start;
  div_stat_t       div_stat;
  logic [DivNumW-1:0] quotient;

  logic [TimeW-1:0]   since_poll;
  logic [TimeW-1:0]   dt;
  logic               too_early;
  logic               hum_bad;
  logic               valid_sample;
  logic               need_div;
  logic signed [HumW:0] rate_delta;
  logic [HumW-1:0]    delta_mag;
  logic [DivNumW-1:0] rate_num;
  logic signed [ValW:0] temp_diff;
  logic signed [HumW:0] hum_diff;
  logic               moved;
  logic [DivNumW-1:0] clamped;
  logic [RateW-1:0]   rate_mag;

  assign out_free = !out_full || !out_stall;
  assign accept   = in_valid && !in_stall;

  assign since_poll = now_ms - last_poll_time;
  assign too_early  = since_poll < {{(TimeW-CfgDataW){1'b0}}, min_interval_ms};
  assign hum_bad    = humidity[ValW-1] || (humidity > $signed(HumMax));
  assign valid_sample = sensor_present && !too_early && read_ok && !hum_bad;
  assign dt         = now_ms - last_valid_time;
  assign need_div   = valid_sample && have_valid_time && (dt > MinDtMs);

  // |delta| * 1000 as (x << 10) - (x << 4) - (x << 3).
  assign rate_delta = $signed({1'b0, humidity[HumW-1:0]}) - $signed({1'b0, last_valid_hum});
  assign delta_mag  = rate_delta[HumW] ? HumW'(-rate_delta) : rate_delta[HumW-1:0];
  assign rate_num   = {delta_mag, 10'b0} - DivNumW'({delta_mag, 4'b0})
                      - DivNumW'({delta_mag, 3'b0});

  assign temp_diff = $signed({temp_cache[ValW-1], temp_cache})
                     - $signed({temperature[ValW-1], temperature});
  assign hum_diff  = $signed({1'b0, hum_cache}) - $signed({1'b0, humidity[HumW-1:0]});
  assign moved = (temp_diff > (ValW+1)'(ChangeThreshold))
              || (temp_diff < -(ValW+1)'(ChangeThreshold))
              || (hum_diff > (HumW+1)'(ChangeThreshold))
              || (hum_diff < -(HumW+1)'(ChangeThreshold));

  assign clamped  = (quotient > RateLimit) ? RateLimit : quotient;
  assign rate_mag = clamped[RateW-1:0];

  hsc_div #(
    .NumW(DivNumW),
    .DenW(DivDenW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rate_num),
    .divisor  (dt),
    .stat     (div_stat),
    .quotient (quotient)
  );

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && need_div) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State-machine outputs.
  always_comb begin
    in_stall  = 1'b1;
    div_start = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall  = !out_free;
        div_start = in_valid && out_free && need_div;
      end
      ST_DIV: begin
        in_stall = 1'b1;
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      min_interval_ms <= MinIntervalReset;
      sensor_present  <= 1'b1;
      last_poll_time  <= '0;
      last_valid_time <= '0;
      have_valid_time <= 1'b0;
      last_valid_hum  <= '0;
      temp_cache      <= '0;
      hum_cache       <= '0;
      rate_reg        <= '0;
      ok_flag         <= 1'b0;
      polled_q        <= 1'b0;
      changed_q       <= 1'b0;
      err_q           <= ERR_NONE;
      rate_neg        <= 1'b0;
      out_full        <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MIN_INTERVAL:   min_interval_ms <= cfg_data;
          CFG_SENSOR_PRESENT: sensor_present  <= cfg_data[0];
          default: ;
        endcase
      end

      if (out_full && !out_stall) begin
        out_full <= 1'b0;
      end

      if (accept) begin
        polled_q  <= 1'b0;
        changed_q <= 1'b0;
        err_q     <= ERR_NONE;
        out_full  <= !need_div;
        if (!sensor_present) begin
          ok_flag <= 1'b0;
          err_q   <= ERR_DISABLED;
        end else if (!too_early) begin
          polled_q       <= 1'b1;
          last_poll_time <= now_ms;
          if (!read_ok) begin
            ok_flag <= 1'b0;
            err_q   <= ERR_READ_FAIL;
          end else if (hum_bad) begin
            ok_flag  <= 1'b0;
            rate_reg <= '0;
            err_q    <= ERR_HUM_RANGE;
          end else begin
            if (!have_valid_time) begin
              rate_reg <= '0;
            end
            rate_neg        <= rate_delta[HumW];
            last_valid_hum  <= humidity[HumW-1:0];
            last_valid_time <= now_ms;
            have_valid_time <= 1'b1;
            changed_q       <= moved;
            temp_cache      <= temperature;
            hum_cache       <= humidity[HumW-1:0];
            ok_flag         <= 1'b1;
          end
        end
      end

      // The rate result finishes the pending transaction.
      if (div_stat.done) begin
        rate_reg <= rate_neg ? -$signed(rate_mag) : $signed(rate_mag);
        out_full <= 1'b1;
      end
    end
  end

  assign out_valid          = out_full;
  assign polled             = polled_q;
  assign changed            = changed_q;
  assign healthy            = ok_flag;
  assign error_code         = err_q;
  assign hum_rate           = rate_reg;
  assign cached_temperature = temp_cache;
  assign cached_humidity    = hum_cache;

endmodule

// ===== rtl/core/hsc_checker.sv =====
// Port-level checker for the humidity sample conditioner, bound to the top level.
// Depends on hsc_pkg and humidity_sample_conditioner_core.
module hsc_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic                              polled,
  input logic                              changed,
  input logic                              healthy,
  input logic [1:0]                        error_code,
  input logic signed [hsc_pkg::RateW-1:0]  hum_rate
);
  import hsc_pkg::*;

  // A held result stays on offer until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  // A new transaction is never taken while a finished result is stuck.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |-> !out_valid || !out_stall)
    else $error("input taken over a stalled result");

  // A refused item leaves the sensor unhealthy, is not a poll and reports no change.
  a_disabled: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code == ERR_DISABLED |-> !healthy && !polled && !changed)
    else $error("disabled result inconsistent");

  // Only a valid sample can report a change, and it leaves the sensor healthy.
  a_changed: assert property (@(posedge clk) disable iff (rst)
    out_valid && changed |-> polled && healthy && error_code == ERR_NONE)
    else $error("change reported without a valid sample");

  a_rate_clamp: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> hum_rate <= 10'sd500 && hum_rate >= -10'sd500)
    else $error("humidity rate outside clamp");

endmodule

bind humidity_sample_conditioner_core hsc_checker u_hsc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .polled     (polled),
  .changed    (changed),
  .healthy    (healthy),
  .error_code (error_code),
  .hum_rate   (hum_rate)
);
